### hdl/ils_pkg.sv
// shared types and constants of the indexed list store
package ils_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_MODIFY = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT
  } state_t;

endpackage

### hdl/ils_if.sv
// valid/ready channel interfaces for list operations and their results
interface ils_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           func;
  logic [ils_pkg::INDEX_W-1:0]          index;
  logic signed [ils_pkg::DATA_W-1:0]    item_value;

  modport source (output valid, output func, output index, output item_value, input ready);
  modport sink   (input valid, input func, input index, input item_value, output ready);
endinterface

interface ils_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ils_pkg::DATA_W-1:0]    read_value;
  logic [1:0]                           status;
  logic [ils_pkg::COUNT_W-1:0]          element_count;
  logic                                 is_empty;

  modport source (output valid, output read_value, output status, output element_count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input element_count,
                  input is_empty, output ready);
endinterface

### hdl/indexed_list_store_unit.sv
// indexed list store: ordered list of signed values in one synchronous memory
//
// Usage: operations arrive on req (func, index, item_value); each transaction
// yields exactly one transaction on rsp (read_value, status, element_count,
// is_empty). func selects append at the tail, read, modify or remove at an
// index. A remove closes the gap by copying every later entry down by one.
// How each operation reaches the registered result:
//   append, modify and any rejected operation: registered on acceptance
//   read in range: one memory read, then the result is registered
//   remove in range: the copy loop moves one entry per cycle over the
//   memory's read and write ports, overlapping the read of the next entry
//   with the write of the previous one, then the result is registered.
// One operation is in flight at a time; the next request is taken as soon as
// the current one has finished and the result register is free or draining.
// A stalled rsp holds its result and blocks req until it is taken.
// Reset (rst, synchronous) empties the list; memory contents are left as they
// are and never read before being written.
module indexed_list_store_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  ils_req_if.sink   req,
  ils_rsp_if.source rsp
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > ils_pkg::INDEX_W) ? CW : ils_pkg::INDEX_W;

  logic [ils_pkg::DATA_W-1:0] mem [DEPTH];
  logic [ils_pkg::DATA_W-1:0] mem_q;

  ils_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   sh_rd;
  logic [AW-1:0]   pend_wr;
  logic            pend;

  logic                             out_valid;
  logic signed [ils_pkg::DATA_W-1:0] out_value;
  ils_pkg::status_t                 out_status;
  logic [ils_pkg::COUNT_W-1:0]      out_count;
  logic                             out_empty;

  logic                        acc;
  ils_pkg::op_t                op;
  logic                        in_range;
  logic                        is_full;
  logic                        issue;
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [ils_pkg::DATA_W-1:0]  mem_wdata;
  logic                        rsp_load;
  logic [ils_pkg::DATA_W-1:0]  rsp_value;
  ils_pkg::status_t            rsp_status;
  logic                        start_shift;

  assign req.ready = (state == ils_pkg::S_IDLE) && (!out_valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign op        = ils_pkg::op_t'(req.func);
  assign in_range  = CMPW'(req.index) < CMPW'(count);
  assign is_full   = count == CW'(DEPTH);
  assign issue     = sh_rd < count;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ils_pkg::S_IDLE: begin
        if (acc && op == ils_pkg::OP_READ && in_range) begin
          state_next = ils_pkg::S_READ;
        end else if (acc && op == ils_pkg::OP_REMOVE && count != '0 && in_range) begin
          state_next = ils_pkg::S_SHIFT;
        end
      end
      ils_pkg::S_READ: begin
        state_next = ils_pkg::S_IDLE;
      end
      ils_pkg::S_SHIFT: begin
        if (!issue && !pend) begin
          state_next = ils_pkg::S_IDLE;
        end
      end
      default: state_next = ils_pkg::S_IDLE;
    endcase
  end

  // memory control, count update and result load
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = '0;
    mem_wdata   = req.item_value;
    rsp_load    = 1'b0;
    rsp_value   = '0;
    rsp_status  = ils_pkg::ST_OK;
    count_next  = count;
    start_shift = 1'b0;
    unique case (state)
      ils_pkg::S_IDLE: begin
        if (acc) begin
          unique case (op)
            ils_pkg::OP_APPEND: begin
              rsp_load = 1'b1;
              if (is_full) begin
                rsp_status = ils_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(count);
                count_next = count + CW'(1);
              end
            end
            ils_pkg::OP_READ: begin
              if (in_range) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(req.index);
              end else begin
                rsp_load   = 1'b1;
                rsp_status = ils_pkg::ST_RANGE;
              end
            end
            ils_pkg::OP_MODIFY: begin
              rsp_load = 1'b1;
              if (in_range) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(req.index);
              end else begin
                rsp_status = ils_pkg::ST_RANGE;
              end
            end
            ils_pkg::OP_REMOVE: begin
              if (count == '0) begin
                rsp_load   = 1'b1;
                rsp_status = ils_pkg::ST_EMPTY;
              end else if (!in_range) begin
                rsp_load   = 1'b1;
                rsp_status = ils_pkg::ST_RANGE;
              end else begin
                start_shift = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ils_pkg::S_READ: begin
        rsp_load  = 1'b1;
        rsp_value = mem_q;
      end
      ils_pkg::S_SHIFT: begin
        // read entry k+1 while the entry read last cycle (k) lands at k-1
        mem_re    = issue;
        mem_raddr = AW'(sh_rd);
        mem_we    = pend;
        mem_waddr = pend_wr;
        mem_wdata = mem_q;
        if (!issue && !pend) begin
          count_next = count - CW'(1);
          rsp_load   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ils_pkg::S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (start_shift) begin
        pend <= 1'b0;
      end else if (state == ils_pkg::S_SHIFT) begin
        pend <= issue;
      end
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_shift) begin
      sh_rd <= CW'(req.index) + CW'(1);
    end else if (state == ils_pkg::S_SHIFT && issue) begin
      sh_rd   <= sh_rd + CW'(1);
      pend_wr <= AW'(sh_rd - CW'(1));
    end
    if (rsp_load) begin
      out_value  <= rsp_value;
      out_status <= rsp_status;
      out_count  <= ils_pkg::COUNT_W'(count_next);
      out_empty  <= count_next == '0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_value    = out_value;
  assign rsp.status        = out_status;
  assign rsp.element_count = out_count;
  assign rsp.is_empty      = out_empty;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count beyond depth");

  a_shift_no_collide: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same entry in one cycle");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(rsp_load && out_valid && !rsp.ready))
    else $error("result overwritten while stalled");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == $past(count) + CW'(1) || count == $past(count) - CW'(1)))
    else $error("element count moved by more than one");

  a_pend_in_shift: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == ils_pkg::S_SHIFT))
    else $error("pending copy outside of a remove");

endmodule

### verif/tb.sv
// testbench for indexed_list_store_unit: directed and random list operations checked against a mirror
`timescale 1ns / 1ps

module tb;

  localparam int LIST_DEPTH   = 64;
  localparam int TOTAL_ITEMS  = 1850;
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic signed [ils_pkg::DATA_W-1:0] read_value;
    ils_pkg::status_t                  status;
    logic [ils_pkg::COUNT_W-1:0]       element_count;
    logic                              is_empty;
  } list_result_t;

  // mirror of the list contents and the results each transaction should produce
  class list_mirror;
    logic signed [ils_pkg::DATA_W-1:0] entries [LIST_DEPTH];
    int unsigned                       count;
    list_result_t                      due [$];
    int                                errors;
    int                                checked;
    int                                peak;
    int                                op_seen [4];
    int                                st_seen [4];

    function void note_op(ils_pkg::op_t f, logic [ils_pkg::INDEX_W-1:0] i,
                          logic signed [ils_pkg::DATA_W-1:0] v);
      list_result_t r;
      r.read_value = '0;
      r.status     = ils_pkg::ST_OK;
      case (f)
        ils_pkg::OP_APPEND: begin
          if (count >= LIST_DEPTH) r.status = ils_pkg::ST_FULL;
          else begin
            entries[count] = v;
            count++;
          end
        end
        ils_pkg::OP_READ: begin
          if (i < count) r.read_value = entries[i];
          else r.status = ils_pkg::ST_RANGE;
        end
        ils_pkg::OP_MODIFY: begin
          if (i < count) entries[i] = v;
          else r.status = ils_pkg::ST_RANGE;
        end
        default: begin
          if (count == 0) r.status = ils_pkg::ST_EMPTY;
          else if (i >= count) r.status = ils_pkg::ST_RANGE;
          else begin
            // close the gap left by the removed entry
            for (int k = i; k + 1 < count; k++) entries[k] = entries[k + 1];
            count--;
          end
        end
      endcase
      r.element_count = count[ils_pkg::COUNT_W-1:0];
      r.is_empty      = (count == 0);
      op_seen[f]++;
      st_seen[r.status]++;
      if (count > peak) peak = count;
      due.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      checked++;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction value=%0d status=%0d count=%0d empty=%0b",
                 $time, got.read_value, got.status, got.element_count, got.is_empty);
        return;
      end
      want = due.pop_front();
      if (got.read_value !== want.read_value) begin
        errors++;
        $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                 got.read_value);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.element_count !== want.element_count) begin
        errors++;
        $display("%0t: element_count expected %0d actual %0d", $time, want.element_count,
                 got.element_count);
      end
      if (got.is_empty !== want.is_empty) begin
        errors++;
        $display("%0t: is_empty expected %0b actual %0b", $time, want.is_empty, got.is_empty);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ils_req_if req_ch ();
  ils_rsp_if rsp_ch ();

  indexed_list_store_unit #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  list_mirror mirror = new();
  int         gap_pct = 15;
  bit         quiet = 1'b0;
  int         sent = 0;
  int         stall_cycles = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic send_op(ils_pkg::op_t f, logic [ils_pkg::INDEX_W-1:0] i,
                         logic signed [ils_pkg::DATA_W-1:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 8);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= f;
    req_ch.index      <= i;
    req_ch.item_value <= v;
    do @(posedge clk); while (!req_ch.ready);
    mirror.note_op(f, i, v);
    sent++;
  endtask

  // receiver: random stall bursts plus one long hold-off so the block backs up
  initial begin
    int  hold;
    bit  long_done;
    hold      = 0;
    long_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else if (!long_done && mirror.checked >= 500) begin
        long_done = 1'b1;
        hold = LONG_HOLD - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
        hold = $urandom_range(1, 8) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    list_result_t got;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.read_value    = rsp_ch.read_value;
      got.status        = ils_pkg::status_t'(rsp_ch.status);
      got.element_count = rsp_ch.element_count;
      got.is_empty      = rsp_ch.is_empty;
      mirror.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int                                mode;
    int                                r;
    ils_pkg::op_t                      f;
    logic [ils_pkg::INDEX_W-1:0]       i;
    logic signed [ils_pkg::DATA_W-1:0] v;
    mode = 0;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= ils_pkg::OP_APPEND;
    req_ch.index      <= '0;
    req_ch.item_value <= '0;
    do @(posedge clk); while (rst);

    // empty list corner cases, then extremes, head, tail and middle removal
    send_op(ils_pkg::OP_REMOVE, 7'd0, 32'sd0);
    send_op(ils_pkg::OP_READ, 7'd0, 32'sd0);
    send_op(ils_pkg::OP_MODIFY, 7'd0, 32'sd5);
    send_op(ils_pkg::OP_APPEND, 7'd127, 32'sh8000_0000);
    send_op(ils_pkg::OP_APPEND, 7'd0, 32'sh7fff_ffff);
    send_op(ils_pkg::OP_APPEND, 7'd0, 32'sd0);
    send_op(ils_pkg::OP_APPEND, 7'd0, -32'sd1);
    send_op(ils_pkg::OP_READ, 7'd0, 32'sd0);
    send_op(ils_pkg::OP_READ, 7'd3, -32'sd1);
    send_op(ils_pkg::OP_READ, 7'd4, 32'sd0);
    send_op(ils_pkg::OP_READ, 7'd127, 32'sd0);
    send_op(ils_pkg::OP_MODIFY, 7'd1, 32'sh5555_5555);
    send_op(ils_pkg::OP_MODIFY, 7'd127, 32'sh2aaa_aaaa);
    send_op(ils_pkg::OP_READ, 7'd1, 32'sd0);
    send_op(ils_pkg::OP_REMOVE, 7'd127, 32'sd0);
    send_op(ils_pkg::OP_REMOVE, 7'd3, 32'sd0);
    send_op(ils_pkg::OP_REMOVE, 7'd0, 32'sd0);
    send_op(ils_pkg::OP_READ, 7'd0, 32'sd0);
    send_op(ils_pkg::OP_APPEND, 7'd0, 32'shaaaa_aaaa);
    send_op(ils_pkg::OP_REMOVE, 7'd1, 32'sd0);
    send_op(ils_pkg::OP_REMOVE, 7'd0, 32'sd0);
    send_op(ils_pkg::OP_REMOVE, 7'd0, 32'sd0);
    send_op(ils_pkg::OP_REMOVE, 7'd0, 32'sd0);

    // phases: 0 grow toward full, 1 shrink toward empty, 2 mixed
    while (sent < TOTAL_ITEMS) begin
      if (sent % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 30;
        endcase
      end
      if (sent >= TOTAL_ITEMS - 150) quiet = 1'b1;
      if (mode == 0 && mirror.count == LIST_DEPTH && $urandom_range(0, 3) == 0)
        mode = $urandom_range(1, 2);
      else if (mode == 1 && mirror.count == 0 && $urandom_range(0, 2) == 0)
        mode = 0;
      else if (mode == 2 && $urandom_range(0, 99) == 0)
        mode = $urandom_range(0, 1);

      r = $urandom_range(0, 99);
      case (mode)
        0: f = (r < 55) ? ils_pkg::OP_APPEND : (r < 70) ? ils_pkg::OP_READ :
               (r < 85) ? ils_pkg::OP_MODIFY : ils_pkg::OP_REMOVE;
        1: f = (r < 10) ? ils_pkg::OP_APPEND : (r < 30) ? ils_pkg::OP_READ :
               (r < 45) ? ils_pkg::OP_MODIFY : ils_pkg::OP_REMOVE;
        default: f = ils_pkg::op_t'(r % 4);
      endcase

      r = $urandom_range(0, 99);
      if (mirror.count == 0 || r < 15)
        i = ils_pkg::INDEX_W'($urandom_range(mirror.count, 127));
      else if (r < 20) i = ils_pkg::INDEX_W'(mirror.count);
      else if (r < 30) i = 7'd0;
      else if (r < 40) i = ils_pkg::INDEX_W'(mirror.count - 1);
      else i = ils_pkg::INDEX_W'($urandom_range(0, mirror.count - 1));

      r = $urandom_range(0, 99);
      if (r < 3) v = 32'sh8000_0000;
      else if (r < 6) v = 32'sh7fff_ffff;
      else if (r < 8) v = 32'sd0;
      else if (r < 10) v = -32'sd1;
      else v = $urandom;

      send_op(f, i, v);
    end
    req_ch.valid <= 1'b0;

    while (mirror.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d operations: %0d append, %0d read, %0d modify, %0d remove; peak length %0d",
             sent, mirror.op_seen[ils_pkg::OP_APPEND], mirror.op_seen[ils_pkg::OP_READ],
             mirror.op_seen[ils_pkg::OP_MODIFY], mirror.op_seen[ils_pkg::OP_REMOVE],
             mirror.peak);
    $display("outcomes: %0d ok, %0d out of range, %0d remove on empty, %0d append on full",
             mirror.st_seen[ils_pkg::ST_OK], mirror.st_seen[ils_pkg::ST_RANGE],
             mirror.st_seen[ils_pkg::ST_EMPTY], mirror.st_seen[ils_pkg::ST_FULL]);
    if (mirror.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
